// ===== src/rbf_pkg.sv =====
// Shared types, register codes and reciprocal table for the RGB box filter.
package rbf_pkg;

	localparam int PIX_W       = 24;
	localparam int CH_W        = 8;
	localparam int POS_W       = 11;
	localparam int SPAN_W      = 3;
	localparam int CFG_DATA_W  = 12;
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = 21;
	localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [1:0]            RADIUS_RESET = 2'd1;

	// Configuration register indexes
	typedef enum logic {
		REG_IMAGE_WIDTH = 1'b0,
		REG_RADIUS      = 1'b1
	} cfg_reg_t;

	// Per-pixel control travelling beside the window data
	typedef struct packed {
		logic              produce;
		logic [SPAN_W-1:0] span;
		logic [POS_W-1:0]  ccol;
		logic [POS_W-1:0]  crow;
	} rbf_meta_t;

	// ceil(2^20 / (2k+1)^2): exact floor quotient for every sum up to 255 * count
	function automatic logic [RECIP_W-1:0] recip(input logic [1:0] k);
		logic [RECIP_W-1:0] r;
		case (k)
			2'd0:    r = 21'd1048576;
			2'd1:    r = 21'd116509;
			2'd2:    r = 21'd41944;
			2'd3:    r = 21'd21400;
			default: r = 21'd1048576;
		endcase
		return r;
	endfunction

endpackage

// ===== src/rbf_line_store.sv =====
// Line store memory: one word per column holding every stored row, with write-to-read forwarding.
module rbf_line_store #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11,
	parameter int DW    = 144
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_q;
	logic [DW-1:0] wb_q;
	logic          fwd_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Capture write data whenever a read and a write coincide; forwarded only on an address match
	always_ff @(posedge clk) begin
		if (rd_en && wr_en) begin
			wb_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? wb_q : rd_q;

endmodule

// ===== src/rbf_window.sv =====
// Square pixel window with per-column channel sums over the active rows.
module rbf_window #(
	parameter int WIN = 7,
	parameter int CSW = 11
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 step,
	input  logic [WIN-1:0]                       load_mask,
	input  logic [WIN-1:0][rbf_pkg::PIX_W-1:0]   col_pix,
	input  rbf_pkg::rbf_meta_t                   meta_in,
	output rbf_pkg::rbf_meta_t                   meta_out,
	output logic [WIN-1:0][CSW-1:0]              sum_r,
	output logic [WIN-1:0][CSW-1:0]              sum_g,
	output logic [WIN-1:0][CSW-1:0]              sum_b
);

	logic [WIN-1:0][WIN-1:0][rbf_pkg::PIX_W-1:0] win_q;
	rbf_pkg::rbf_meta_t                          meta_s2;
	rbf_pkg::rbf_meta_t                          meta_s3;
	logic [WIN-1:0][CSW-1:0]                     cs_r, cs_g, cs_b;
	logic [WIN-1:0][CSW-1:0]                     sum_r_s3, sum_g_s3, sum_b_s3;

	// Shift the window left and load the new right-hand column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (step) begin
			for (int j = 0; j < WIN; j++) begin
				for (int dx = 0; dx < WIN - 1; dx++) begin
					win_q[j][dx] <= win_q[j][dx+1];
				end
				if (load_mask[j]) begin
					win_q[j][WIN-1] <= col_pix[j];
				end
			end
		end
	end

	// Column sums over rows zero to span
	always_comb begin
		for (int dx = 0; dx < WIN; dx++) begin
			cs_r[dx] = '0;
			cs_g[dx] = '0;
			cs_b[dx] = '0;
			for (int j = 0; j < WIN; j++) begin
				if (j <= int'(meta_s2.span)) begin
					cs_r[dx] = cs_r[dx] + CSW'(win_q[j][dx][23:16]);
					cs_g[dx] = cs_g[dx] + CSW'(win_q[j][dx][15:8]);
					cs_b[dx] = cs_b[dx] + CSW'(win_q[j][dx][7:0]);
				end
			end
		end
	end

	// Advance control and register the column sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s2 <= '0;
			meta_s3 <= '0;
		end else if (adv) begin
			meta_s2 <= meta_in;
			meta_s3 <= meta_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_r_s3 <= cs_r;
			sum_g_s3 <= cs_g;
			sum_b_s3 <= cs_b;
		end
	end

	assign meta_out = meta_s3;
	assign sum_r    = sum_r_s3;
	assign sum_g    = sum_g_s3;
	assign sum_b    = sum_b_s3;

endmodule

// ===== src/rbf_mean.sv =====
// Window total and reciprocal multiply giving the floor mean per channel.
module rbf_mean #(
	parameter int WIN = 7,
	parameter int CSW = 11,
	parameter int TSW = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  rbf_pkg::rbf_meta_t                meta_in,
	input  logic [WIN-1:0][CSW-1:0]           sum_r,
	input  logic [WIN-1:0][CSW-1:0]           sum_g,
	input  logic [WIN-1:0][CSW-1:0]           sum_b,
	output logic                              out_valid,
	output logic [rbf_pkg::CH_W-1:0]          mean_red,
	output logic [rbf_pkg::CH_W-1:0]          mean_green,
	output logic [rbf_pkg::CH_W-1:0]          mean_blue,
	output logic [rbf_pkg::POS_W-1:0]         center_column,
	output logic [rbf_pkg::POS_W-1:0]         center_row
);

	localparam int PW = TSW + rbf_pkg::RECIP_W;

	rbf_pkg::rbf_meta_t             meta_s4;
	logic [TSW-1:0]                 tot_r, tot_g, tot_b;
	logic [TSW-1:0]                 tot_r_s4, tot_g_s4, tot_b_s4;
	logic [rbf_pkg::RECIP_W-1:0]    rcp;
	logic [PW-1:0]                  prod_r, prod_g, prod_b;
	logic                           out_valid_q;
	logic [rbf_pkg::CH_W-1:0]       mean_red_q, mean_green_q, mean_blue_q;
	logic [rbf_pkg::POS_W-1:0]      ccol_q, crow_q;

	// Add the columns that lie inside the active window
	always_comb begin
		tot_r = '0;
		tot_g = '0;
		tot_b = '0;
		for (int dx = 0; dx < WIN; dx++) begin
			if (dx >= (WIN - 1) - int'(meta_in.span)) begin
				tot_r = tot_r + TSW'(sum_r[dx]);
				tot_g = tot_g + TSW'(sum_g[dx]);
				tot_b = tot_b + TSW'(sum_b[dx]);
			end
		end
	end

	// Multiply by the reciprocal of the window count
	assign rcp    = rbf_pkg::recip(meta_s4.span[2:1]);
	assign prod_r = PW'(tot_r_s4) * PW'(rcp);
	assign prod_g = PW'(tot_g_s4) * PW'(rcp);
	assign prod_b = PW'(tot_b_s4) * PW'(rcp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s4     <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			meta_s4     <= meta_in;
			out_valid_q <= meta_s4.produce;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tot_r_s4     <= tot_r;
			tot_g_s4     <= tot_g;
			tot_b_s4     <= tot_b;
			mean_red_q   <= prod_r[rbf_pkg::RECIP_SHIFT +: rbf_pkg::CH_W];
			mean_green_q <= prod_g[rbf_pkg::RECIP_SHIFT +: rbf_pkg::CH_W];
			mean_blue_q  <= prod_b[rbf_pkg::RECIP_SHIFT +: rbf_pkg::CH_W];
			ccol_q       <= meta_s4.ccol;
			crow_q       <= meta_s4.crow;
		end
	end

	assign out_valid     = out_valid_q;
	assign mean_red      = mean_red_q;
	assign mean_green    = mean_green_q;
	assign mean_blue     = mean_blue_q;
	assign center_column = ccol_q;
	assign center_row    = crow_q;

endmodule

// ===== src/rgb_box_filter_core.sv =====
// Path: stage one, window, column sums, totals, then the output register.
// Throughput: one pixel per cycle; the line store is read once per pixel and written
// back unless the radius is zero; the whole pipeline holds only while a result waits.
// Reset: counters clear, width returns to 640 and radius to 1, the window
// clears to zero; the line store is not cleared and holds data once rows pass.
// Top level of the RGB box filter: counters, line-store read-modify-write, pipeline.
module rgb_box_filter_core #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_RADIUS = 3,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // red, green, blue
	input  logic        s_axis_tuser,   // frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // mean_red, mean_green, mean_blue, center_column,
	                                    // center_row, zero fill
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [rbf_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW      = $clog2(MAX_WIDTH);
	localparam int WW      = CW + 1;
	localparam int KM      = (MAX_RADIUS < 3) ? MAX_RADIUS : 3;
	localparam int LINES   = 2 * KM;
	localparam int LW      = $clog2(LINES);
	localparam int WIN     = 2 * MAX_RADIUS + 1;
	localparam int CSW     = $clog2(WIN * 255 + 1);
	localparam int TSW     = $clog2(WIN * WIN * 255 + 1);
	localparam int DW      = LINES * rbf_pkg::PIX_W;
	localparam int ROW_CAP = ((MAX_HEIGHT - 1) < 2047) ? (MAX_HEIGHT - 1) : 2047;
	localparam int SW      = rbf_pkg::SPAN_W;
	localparam int PW      = rbf_pkg::POS_W;

	// Configuration registers
	logic [rbf_pkg::CFG_DATA_W-1:0] width_q;
	logic [1:0]                     radius_q;

	// Frame position state
	logic [CW-1:0] cc_q;
	logic [PW-1:0] rc_q;
	logic [SW-1:0] ls_q;

	// Stage one: pixel waiting for its line-store word
	logic                       s1_valid_q;
	logic [rbf_pkg::PIX_W-1:0]  pix_s1;
	logic [SW-1:0]              slot_s1;
	logic [SW-1:0]              span_s1;
	logic [CW-1:0]              col_s1;
	rbf_pkg::rbf_meta_t         meta_s1;

	logic                       adv;
	logic                       accept;
	logic [1:0]                 k_eff;
	logic [SW-1:0]              span;
	logic [WW-1:0]              w_eff;
	logic [CW-1:0]              cc_a, col, cc_n;
	logic [WW-1:0]              cc_b;
	logic [PW-1:0]              rc_a, rc_n;
	logic [SW-1:0]              ls_a, ls_n, slot;
	logic                       produce;
	logic [31:0]                ccol_w, crow_w;
	logic [rbf_pkg::PIX_W-1:0]  pix_in;

	logic [DW-1:0]                        rd_word, wr_word;
	logic [LINES-1:0][rbf_pkg::PIX_W-1:0] lanes;
	logic                                 wr_en;
	logic [WIN-1:0]                       load_mask;
	logic [WIN-1:0][rbf_pkg::PIX_W-1:0]   col_pix;
	logic                                 step;

	rbf_pkg::rbf_meta_t        meta_s3;
	logic [WIN-1:0][CSW-1:0]   sum_r, sum_g, sum_b;
	logic                      out_valid;
	logic [rbf_pkg::CH_W-1:0]  mean_red, mean_green, mean_blue;
	logic [PW-1:0]             center_column, center_row;

	// Reduce a slot number below the span with up to three conditional subtracts
	function automatic logic [SW-1:0] slot_mod(input logic [SW:0] v, input logic [SW-1:0] sp);
		logic [SW:0] t;
		t = v;
		if (sp == '0) begin
			t = '0;
		end else begin
			for (int i = 0; i < 3; i++) begin
				if (t >= {1'b0, sp}) begin
					t = t - {1'b0, sp};
				end
			end
		end
		return t[SW-1:0];
	endfunction

	function automatic logic [PW-1:0] row_inc(input logic [PW-1:0] r);
		return (32'(r) < 32'(ROW_CAP)) ? r + 1'b1 : r;
	endfunction

	// Capture configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rbf_pkg::WIDTH_RESET;
			radius_q <= rbf_pkg::RADIUS_RESET;
		end else if (cfg_we) begin
			case (rbf_pkg::cfg_reg_t'(cfg_index))
				rbf_pkg::REG_IMAGE_WIDTH: width_q  <= cfg_data;
				rbf_pkg::REG_RADIUS:      radius_q <= cfg_data[1:0];
				default:                  width_q  <= width_q;
			endcase
		end
	end

	// Whole pipeline moves when the output register is free or being drained
	assign adv           = !out_valid || m_axis_tready;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;
	assign pix_in        = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

	// Saturate settings and step the frame position
	always_comb begin
		int w_int;
		k_eff = (32'(radius_q) > 32'(KM)) ? 2'(KM) : radius_q;
		span  = {k_eff, 1'b0};
		if (width_q == '0) begin
			w_int = 1;
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_int = MAX_WIDTH;
		end else begin
			w_int = int'(width_q);
		end
		w_eff = WW'(w_int);

		if (s_axis_tuser) begin
			cc_a = '0;
			rc_a = '0;
			ls_a = '0;
		end else if ({1'b0, cc_q} >= w_eff) begin
			cc_a = '0;
			rc_a = row_inc(rc_q);
			ls_a = slot_mod({1'b0, ls_q} + 1'b1, span);
		end else begin
			cc_a = cc_q;
			rc_a = rc_q;
			ls_a = ls_q;
		end

		col  = cc_a;
		slot = slot_mod({1'b0, ls_a}, span);
		cc_b = {1'b0, col} + 1'b1;
		if (cc_b >= w_eff) begin
			cc_n = '0;
			rc_n = row_inc(rc_a);
			ls_n = slot_mod({1'b0, ls_a} + 1'b1, span);
		end else begin
			cc_n = cc_b[CW-1:0];
			rc_n = rc_a;
			ls_n = ls_a;
		end

		produce = (rc_a >= PW'(span)) && (col >= CW'(span));
		ccol_w  = 32'(col) - 32'(k_eff);
		crow_w  = 32'(rc_a) - 32'(k_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q       <= '0;
			rc_q       <= '0;
			ls_q       <= '0;
			s1_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= accept;
			if (accept) begin
				cc_q <= cc_n;
				rc_q <= rc_n;
				ls_q <= ls_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1          <= pix_in;
			slot_s1         <= slot;
			span_s1         <= span;
			col_s1          <= col;
			meta_s1.produce <= produce;
			meta_s1.span    <= span;
			meta_s1.ccol    <= ccol_w[PW-1:0];
			meta_s1.crow    <= crow_w[PW-1:0];
		end
	end

	rbf_line_store #(
		.DEPTH(MAX_WIDTH),
		.AW   (CW),
		.DW   (DW)
	) u_line_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_addr(col),
		.wr_en  (wr_en),
		.wr_addr(col_s1),
		.wr_data(wr_word),
		.rd_data(rd_word)
	);

	// Build the new window column and the written-back line-store word
	always_comb begin
		logic [SW:0] idx;
		lanes = rd_word;
		for (int i = 0; i < LINES; i++) begin
			wr_word[i*rbf_pkg::PIX_W +: rbf_pkg::PIX_W] =
				(32'(slot_s1) == 32'(i)) ? pix_s1 : lanes[i];
		end
		for (int j = 0; j < WIN; j++) begin
			idx = {1'b0, slot_s1} + (SW+1)'(j);
			if (idx >= {1'b0, span_s1}) begin
				idx = idx - {1'b0, span_s1};
			end
			if (j < int'(span_s1)) begin
				load_mask[j] = 1'b1;
				col_pix[j]   = lanes[idx[LW-1:0]];
			end else if (j == int'(span_s1)) begin
				load_mask[j] = 1'b1;
				col_pix[j]   = pix_s1;
			end else begin
				load_mask[j] = 1'b0;
				col_pix[j]   = pix_s1;
			end
		end
	end

	assign step  = adv && s1_valid_q;
	assign wr_en = step && (span_s1 != '0);

	rbf_window #(
		.WIN(WIN),
		.CSW(CSW)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.step     (step),
		.load_mask(load_mask),
		.col_pix  (col_pix),
		.meta_in  (s1_valid_q ? meta_s1 : '0),
		.meta_out (meta_s3),
		.sum_r    (sum_r),
		.sum_g    (sum_g),
		.sum_b    (sum_b)
	);

	rbf_mean #(
		.WIN(WIN),
		.CSW(CSW),
		.TSW(TSW)
	) u_mean (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.meta_in      (meta_s3),
		.sum_r        (sum_r),
		.sum_g        (sum_g),
		.sum_b        (sum_b),
		.out_valid    (out_valid),
		.mean_red     (mean_red),
		.mean_green   (mean_green),
		.mean_blue    (mean_blue),
		.center_column(center_column),
		.center_row   (center_row)
	);

	// Pack the result transfer
	assign m_axis_tvalid = out_valid;
	assign m_axis_tdata  = {2'b00, center_row, center_column, mean_blue, mean_green, mean_red};

endmodule

// ===== dv/rgb_box_filter_core_tb.sv =====
// Self-checking testbench for the RGB box filter core: stream driver, result monitor, predictor.
module rgb_box_filter_core_tb;

	localparam int MAX_W       = 2048;
	localparam int MAX_K       = 3;
	localparam int WIN         = 2 * MAX_K + 1;
	localparam int ROW_CAP     = 2047;
	localparam int SETTLE_CYC  = 16;
	localparam int HOLD_CYC    = 400;
	localparam int STALL_LIMIT = 5000;
	localparam int CFG_W       = rbf_pkg::CFG_DATA_W;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_start;
	} pixel_t;

	typedef struct {
		logic [7:0]  mean_red;
		logic [7:0]  mean_green;
		logic [7:0]  mean_blue;
		logic [10:0] center_column;
		logic [10:0] center_row;
	} mean_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata;
	logic                 s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [47:0]          m_axis_tdata;
	logic                 cfg_we;
	rbf_pkg::cfg_reg_t    cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	rgb_box_filter_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	pixel_t pending_q[$];
	mean_t  mean_q[$];
	int     send_idle_pct;
	int     recv_stall_pct;
	int     n_pixels;
	int     n_means;
	int     n_errors;
	int     quiet_cycles;
	bit     hold_ask;
	bit     hold_started;
	int     hold_left;

	// Predictor state
	logic [23:0]     line_mem [0:2*MAX_K*MAX_W-1];
	logic [23:0]     win_pix [0:WIN-1][0:WIN-1];
	int unsigned     col_cnt;
	int unsigned     row_cnt;
	int unsigned     line_slot;
	logic [11:0]     width_reg;
	logic [1:0]      radius_reg;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Step the row counters at the end of a row
	task automatic wrap_row(input int unsigned span);
		col_cnt = 0;
		if (row_cnt < ROW_CAP)
			row_cnt++;
		line_slot = (span > 0) ? (line_slot + 1) % span : 0;
	endtask

	// Take one accepted pixel into the predictor; queue the mean it yields
	task automatic filter_pixel(input pixel_t p);
		int unsigned w, k, span, col, s, sr, sg, sb, cnt;
		mean_t m;
		w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
		k = radius_reg;
		span = 2 * k;
		if (p.frame_start) begin
			col_cnt = 0;
			row_cnt = 0;
			line_slot = 0;
		end else if (col_cnt >= w) begin
			wrap_row(span);
		end
		col = col_cnt;
		for (int j = 0; j < WIN; j++)
			for (int dx = 0; dx < WIN - 1; dx++)
				win_pix[j][dx] = win_pix[j][dx + 1];
		s = (span > 0) ? line_slot % span : 0;
		for (int j = 0; j < span; j++)
			win_pix[j][WIN-1] = line_mem[((s + j) % span) * MAX_W + col];
		win_pix[span][WIN-1] = {p.red, p.green, p.blue};
		if (span > 0)
			line_mem[s * MAX_W + col] = {p.red, p.green, p.blue};
		if (row_cnt >= span && col >= span) begin
			sr = 0;
			sg = 0;
			sb = 0;
			for (int j = 0; j <= span; j++)
				for (int dx = WIN - 1 - span; dx < WIN; dx++) begin
					sr += win_pix[j][dx][23:16];
					sg += win_pix[j][dx][15:8];
					sb += win_pix[j][dx][7:0];
				end
			cnt = (span + 1) * (span + 1);
			m.mean_red      = 8'(sr / cnt);
			m.mean_green    = 8'(sg / cnt);
			m.mean_blue     = 8'(sb / cnt);
			m.center_column = 11'(col - k);
			m.center_row    = 11'(row_cnt - k);
			mean_q.push_back(m);
		end
		col_cnt = col + 1;
		if (col_cnt >= w)
			wrap_row(span);
	endtask

	// Driver: offer pending pixels, hold while the core stalls
	always @(posedge clk) begin
		pixel_t nx;
		if (s_axis_tvalid && s_axis_tready) begin
			filter_pixel(pending_q.pop_front());
			n_pixels++;
		end
		if (!(s_axis_tvalid && !s_axis_tready)) begin
			if (pending_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				nx = pending_q[0];
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {nx.blue, nx.green, nx.red};
				s_axis_tuser  <= nx.frame_start;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: check each result transfer, drive random back-pressure
	always @(posedge clk) begin
		mean_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			n_means++;
			if (mean_q.size() == 0) begin
				$error("unexpected result %h", m_axis_tdata);
				n_errors++;
			end else begin
				e = mean_q.pop_front();
				if (m_axis_tdata[7:0] !== e.mean_red) begin
					$error("mean_red exp %0d got %0d", e.mean_red, m_axis_tdata[7:0]);
					n_errors++;
				end
				if (m_axis_tdata[15:8] !== e.mean_green) begin
					$error("mean_green exp %0d got %0d", e.mean_green, m_axis_tdata[15:8]);
					n_errors++;
				end
				if (m_axis_tdata[23:16] !== e.mean_blue) begin
					$error("mean_blue exp %0d got %0d", e.mean_blue, m_axis_tdata[23:16]);
					n_errors++;
				end
				if (m_axis_tdata[34:24] !== e.center_column) begin
					$error("center_column exp %0d got %0d", e.center_column,
						m_axis_tdata[34:24]);
					n_errors++;
				end
				if (m_axis_tdata[45:35] !== e.center_row) begin
					$error("center_row exp %0d got %0d", e.center_row, m_axis_tdata[45:35]);
					n_errors++;
				end
			end
		end
		if (hold_ask && !hold_started) begin
			hold_started  <= 1'b1;
			hold_left     <= HOLD_CYC;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// Watchdog: fail if no transfer happens for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("rgb_box_filter_core_tb: done, errors");
			$finish;
		end
	end

	task automatic write_reg(input rbf_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == rbf_pkg::REG_IMAGE_WIDTH)
			width_reg = val;
		else
			radius_reg = val[1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_shape(input int w, input int k);
		write_reg(rbf_pkg::REG_IMAGE_WIDTH, CFG_W'(w));
		write_reg(rbf_pkg::REG_RADIUS, CFG_W'(k));
	endtask

	// Wait until every pixel is in and every mean is out, then drain the pipe
	task automatic settle();
		while (pending_q.size() > 0 || s_axis_tvalid || mean_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic push_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic fs);
		pixel_t p;
		p.red = r;
		p.green = g;
		p.blue = b;
		p.frame_start = fs;
		pending_q.push_back(p);
	endtask

	// Queue a frame of random pixels; noisy frames restart now and then
	task automatic queue_frame(input int npix, input bit noise, input bit fresh);
		for (int i = 0; i < npix; i++)
			push_pixel(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
				8'($urandom_range(255, 0)),
				(fresh && i == 0) || (noise && $urandom_range(49, 0) == 0));
	endtask

	initial begin
		int w, k, rows, budget;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = rbf_pkg::REG_IMAGE_WIDTH;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		n_pixels = 0;
		n_means = 0;
		n_errors = 0;
		quiet_cycles = 0;
		hold_ask = 1'b0;
		hold_started = 1'b0;
		hold_left = 0;
		for (int i = 0; i < 2 * MAX_K * MAX_W; i++)
			line_mem[i] = '0;
		for (int j = 0; j < WIN; j++)
			for (int dx = 0; dx < WIN; dx++)
				win_pix[j][dx] = '0;
		col_cnt = 0;
		row_cnt = 0;
		line_slot = 0;
		width_reg = rbf_pkg::WIDTH_RESET;
		radius_reg = rbf_pkg::RADIUS_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extreme channel values through a 3x3 window
		set_shape(4, 1);
		for (int i = 0; i < 12; i++)
			push_pixel((i % 2) ? 8'hFF : 8'h00, (i % 3) ? 8'h00 : 8'hFF,
				(i > 5) ? 8'hFF : 8'h00, i == 0);
		settle();
		// Width zero behaves as one; radius zero passes pixels through
		set_shape(0, 0);
		queue_frame(4, 0, 1);
		settle();
		// Width beyond the maximum saturates
		set_shape(4095, 0);
		queue_frame(5, 0, 1);
		settle();
		// Narrow image: never a result
		set_shape(4, 2);
		queue_frame(12, 0, 1);
		settle();
		// Width shrunk part way through a row
		set_shape(16, 1);
		queue_frame(40, 0, 1);
		settle();
		write_reg(rbf_pkg::REG_IMAGE_WIDTH, CFG_W'(6));
		queue_frame(30, 0, 0);
		settle();

		// Random frames over four idling phases
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 86 : 34) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 86 : 34) : 0;
			if (ph == 0) begin
				// Long receiver hold-off while the sender keeps offering
				set_shape(20, 1);
				hold_ask = 1'b1;
				queue_frame(20 * 6, 0, 1);
				settle();
			end
			budget = 220;
			while (budget > 0) begin
				k = $urandom_range(3, 0);
				if (k > 0 && $urandom_range(9, 0) == 0)
					w = $urandom_range(2 * k, 1);
				else
					w = $urandom_range(24, 2 * k + 1);
				rows = $urandom_range(2 * k + 4, 2 * k + 1);
				set_shape(w, k);
				queue_frame(w * rows + $urandom_range(w - 1, 0), 1, 1);
				budget -= w * rows;
				settle();
			end
		end

		$display("%0d pixels in, %0d means checked across radii 0-3, width extremes,",
			n_pixels, n_means);
		$display("narrow images, mid-row width change, a long hold-off and four idling phases");
		if (n_errors == 0)
			$display("rgb_box_filter_core_tb: done, clean");
		else
			$display("rgb_box_filter_core_tb: done, errors");
		$finish;
	end

endmodule
